// ----- rtl/pdrot_pkg.sv -----
// Package for the Poincare disk rotation unit.
// Holds the default coordinate width, the fraction limits, the register indexes
// and reset values. Used by the top level and the checker; depends on nothing.
package pdrot_pkg;

  localparam int CoordBitsDef = 16;
  localparam int TrigFrac     = 15;
  localparam int MaxWorkFrac  = 28;

  localparam logic RegSine   = 1'b0;
  localparam logic RegCosine = 1'b1;

  localparam logic signed [15:0] SineRst   = 16'sh0000;
  localparam logic signed [15:0] CosineRst = 16'sh7fff;

endpackage

// ----- rtl/poincare_disk_rotate_about_point_unit.sv -----
// Top level of the Poincare disk rotation unit: maps the centre to the origin,
// rotates, and maps back, all in one pipeline.
// Depends on pdrot_pkg and pdrot_div.
//
// Use: a request on the input channel (in_valid_i, in_stall_o) carries a centre
// and a point, both signed Q1.(COORD_BITS-1). Each request gives exactly one
// result on the output channel (out_valid_o, out_stall_i) with the rotated
// point and an overflow flag, in request order.
// The sine and cosine of the angle are written over the APB port while the unit
// is idle; register 0 is the sine, register 1 the cosine.
// With W = min(COORD_BITS-1, 28), the pipeline has eleven multiply and add
// stages and two dividers of W+3 stages each, one quotient bit per divide step.
// A request can enter every cycle that in_stall_o is low; throughput is one per cycle.
// Every stage holds its own valid bit, so a stalled receiver backs up only the
// stages that are full; empty stages keep taking requests until the whole
// pipeline is full, and only then in_stall_o rises. Nothing is lost or repeated.
// Reset clears all valid bits and sets the sine to 0 and the cosine to 32767.
module poincare_disk_rotate_about_point_unit
  import pdrot_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] rotated_x_o,
  output logic signed [COORD_BITS-1:0] rotated_y_o,
  output logic                         overflow_o
);

  localparam int WF     = (COORD_BITS - 1 < MaxWorkFrac) ? COORD_BITS - 1 : MaxWorkFrac;
  localparam int DROP   = COORD_BITS - 1 - WF;
  localparam int XW     = WF + 7;
  localparam int NW     = 2 * WF + 7;
  localparam int DW     = WF + 6;
  localparam int HALF_W = 1 << (WF - 1);
  localparam int HALF_D = (DROP > 0) ? (1 << (DROP - 1)) : 0;

  localparam logic signed [XW-1:0] ONE = XW'(1 << WF);

  // Product rounded half up to WF fraction bits.
  function automatic logic signed [XW-1:0] mulw(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = a * b + (2*XW)'(HALF_W);
    return XW'(p >>> WF);
  endfunction

  // Full product for the quotient numerators.
  function automatic logic signed [NW-1:0] mulf(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = a * b;
    return $signed(p[NW-1:0]);
  endfunction

  function automatic logic signed [XW-1:0] rnd_in(input logic signed [COORD_BITS-1:0] x);
    logic signed [COORD_BITS:0] t;
    t = (COORD_BITS+1)'(x) + (COORD_BITS+1)'(HALF_D);
    return XW'(t >>> DROP);
  endfunction

  // Configuration registers.
  logic signed [15:0] sine_q;
  logic signed [15:0] cosine_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q   <= SineRst;
      cosine_q <= CosineRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegSine:   sine_q   <= $signed(pwdata[15:0]);
        RegCosine: cosine_q <= $signed(pwdata[15:0]);
        default:   sine_q   <= sine_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == RegCosine) ? 32'(cosine_q) : 32'(sine_q);

  logic signed [XW-1:0] sn;
  logic signed [XW-1:0] cs;

  if (WF >= TrigFrac) begin : g_trig_up
    assign sn = XW'(sine_q) <<< (WF - TrigFrac);
    assign cs = XW'(cosine_q) <<< (WF - TrigFrac);
  end else begin : g_trig_dn
    assign sn = (XW'(sine_q) + XW'(1 << (TrigFrac - WF - 1))) >>> (TrigFrac - WF);
    assign cs = (XW'(cosine_q) + XW'(1 << (TrigFrac - WF - 1))) >>> (TrigFrac - WF);
  end

  // Valid bits and ready chain of the multiply and add stages.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9, rdy10, rdy11;
  logic diva_rdy, diva_vld, divb_rdy, divb_vld;

  assign rdy11 = !v11_q || divb_rdy;
  assign rdy10 = !v10_q || rdy11;
  assign rdy9  = !v9_q  || rdy10;
  assign rdy8  = !v8_q  || rdy9;
  assign rdy7  = !v7_q  || rdy8;
  assign rdy6  = !v6_q  || rdy7;
  assign rdy5  = !v5_q  || diva_rdy;
  assign rdy4  = !v4_q  || rdy5;
  assign rdy3  = !v3_q  || rdy4;
  assign rdy2  = !v2_q  || rdy3;
  assign rdy1  = !v1_q  || rdy2;

  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q  <= in_valid_i;
      if (rdy2)  v2_q  <= v1_q;
      if (rdy3)  v3_q  <= v2_q;
      if (rdy4)  v4_q  <= v3_q;
      if (rdy5)  v5_q  <= v4_q;
      if (rdy6)  v6_q  <= diva_vld;
      if (rdy7)  v7_q  <= v6_q;
      if (rdy8)  v8_q  <= v7_q;
      if (rdy9)  v9_q  <= v8_q;
      if (rdy10) v10_q <= v9_q;
      if (rdy11) v11_q <= v10_q;
    end
  end

  // First transform: z -> (z - c) / (1 - conj(c) z).
  logic signed [XW-1:0] cx1_q, cy1_q, px1_q, py1_q;
  logic signed [XW-1:0] cx2_q, cy2_q, a1_2_q, a2_2_q, a3_2_q, a4_2_q, fx2_q, fy2_q;
  logic signed [XW-1:0] cx3_q, cy3_q, u3_q, v3d_q, fx3_q, fy3_q;
  logic signed [XW-1:0] cx4_q, cy4_q, uu4_q, vv4_q;
  logic signed [NW-1:0] n1_4_q, n2_4_q, n3_4_q, n4_4_q;
  logic signed [XW-1:0] cx5_q, cy5_q;
  logic signed [NW-1:0] nx5_q, ny5_q;
  logic        [DW-1:0] q5_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      cx1_q <= rnd_in(center_x_i);
      cy1_q <= rnd_in(center_y_i);
      px1_q <= rnd_in(point_x_i);
      py1_q <= rnd_in(point_y_i);
    end
    if (rdy2 && v1_q) begin
      a1_2_q <= mulw(cx1_q, px1_q);
      a2_2_q <= mulw(cy1_q, py1_q);
      a3_2_q <= mulw(px1_q, cy1_q);
      a4_2_q <= mulw(cx1_q, py1_q);
      fx2_q  <= px1_q - cx1_q;
      fy2_q  <= py1_q - cy1_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
    end
    if (rdy3 && v2_q) begin
      u3_q  <= ONE - (a1_2_q + a2_2_q);
      v3d_q <= a3_2_q - a4_2_q;
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;
    end
    if (rdy4 && v3_q) begin
      n1_4_q <= mulf(fx3_q, u3_q);
      n2_4_q <= mulf(fy3_q, v3d_q);
      n3_4_q <= mulf(fy3_q, u3_q);
      n4_4_q <= mulf(fx3_q, v3d_q);
      uu4_q  <= mulw(u3_q, u3_q);
      vv4_q  <= mulw(v3d_q, v3d_q);
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
    end
    if (rdy5 && v4_q) begin
      nx5_q <= n1_4_q + n2_4_q;
      ny5_q <= n3_4_q - n4_4_q;
      q5_q  <= DW'(uu4_q + vv4_q);
      cx5_q <= cx4_q;
      cy5_q <= cy4_q;
    end
  end

  logic signed [WF:0]     mx, my;
  logic                   ovfa;
  logic [2*XW-1:0]        pay_a;

  pdrot_div #(
    .FRAC (WF),
    .NW   (NW),
    .DW   (DW),
    .PW   (2 * XW)
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .ready_o (diva_rdy),
    .num_a_i (nx5_q),
    .num_b_i (ny5_q),
    .den_i   (q5_q),
    .pay_i   ({cx5_q, cy5_q}),
    .valid_o (diva_vld),
    .ready_i (rdy6),
    .quo_a_o (mx),
    .quo_b_o (my),
    .ovf_o   (ovfa),
    .pay_o   (pay_a)
  );

  // Rotation about the origin, then the inverse transform w -> (w + c) / (1 + conj(c) w).
  logic signed [XW-1:0] mxe, mye;
  logic signed [XW-1:0] cx6_q, cy6_q, t1_q, t2_q, t3_q, t4_q;
  logic signed [XW-1:0] cx7_q, cy7_q, rx7_q, ry7_q;
  logic signed [XW-1:0] cx8_q, cy8_q, a1_8_q, a2_8_q, a3_8_q, a4_8_q, fx8_q, fy8_q;
  logic signed [XW-1:0] u9_q, v9d_q, fx9_q, fy9_q;
  logic signed [XW-1:0] uu10_q, vv10_q;
  logic signed [NW-1:0] n1_10_q, n2_10_q, n3_10_q, n4_10_q;
  logic signed [NW-1:0] nx11_q, ny11_q;
  logic        [DW-1:0] q11_q;
  logic                 o6_q, o7_q, o8_q, o9_q, o10_q, o11_q;

  assign mxe = XW'(mx);
  assign mye = XW'(my);

  always_ff @(posedge clk_i) begin
    if (rdy6 && diva_vld) begin
      t1_q  <= mulw(cs, mxe);
      t2_q  <= mulw(sn, mye);
      t3_q  <= mulw(sn, mxe);
      t4_q  <= mulw(cs, mye);
      cx6_q <= $signed(pay_a[2*XW-1:XW]);
      cy6_q <= $signed(pay_a[XW-1:0]);
      o6_q  <= ovfa;
    end
    if (rdy7 && v6_q) begin
      rx7_q <= t1_q - t2_q;
      ry7_q <= t3_q + t4_q;
      cx7_q <= cx6_q;
      cy7_q <= cy6_q;
      o7_q  <= o6_q;
    end
    if (rdy8 && v7_q) begin
      a1_8_q <= mulw(cx7_q, rx7_q);
      a2_8_q <= mulw(cy7_q, ry7_q);
      a3_8_q <= mulw(rx7_q, cy7_q);
      a4_8_q <= mulw(cx7_q, ry7_q);
      fx8_q  <= rx7_q + cx7_q;
      fy8_q  <= ry7_q + cy7_q;
      cx8_q  <= cx7_q;
      cy8_q  <= cy7_q;
      o8_q   <= o7_q;
    end
    if (rdy9 && v8_q) begin
      u9_q  <= ONE + (a1_8_q + a2_8_q);
      v9d_q <= a4_8_q - a3_8_q;
      fx9_q <= fx8_q;
      fy9_q <= fy8_q;
      o9_q  <= o8_q;
    end
    if (rdy10 && v9_q) begin
      n1_10_q <= mulf(fx9_q, u9_q);
      n2_10_q <= mulf(fy9_q, v9d_q);
      n3_10_q <= mulf(fy9_q, u9_q);
      n4_10_q <= mulf(fx9_q, v9d_q);
      uu10_q  <= mulw(u9_q, u9_q);
      vv10_q  <= mulw(v9d_q, v9d_q);
      o10_q   <= o9_q;
    end
    if (rdy11 && v10_q) begin
      nx11_q <= n1_10_q + n2_10_q;
      ny11_q <= n3_10_q - n4_10_q;
      q11_q  <= DW'(uu10_q + vv10_q);
      o11_q  <= o10_q;
    end
  end

  logic signed [WF:0] fxq, fyq;
  logic               ovfb;
  logic               ovf_prev;

  pdrot_div #(
    .FRAC (WF),
    .NW   (NW),
    .DW   (DW),
    .PW   (1)
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v11_q),
    .ready_o (divb_rdy),
    .num_a_i (nx11_q),
    .num_b_i (ny11_q),
    .den_i   (q11_q),
    .pay_i   (o11_q),
    .valid_o (divb_vld),
    .ready_i (!out_stall_i),
    .quo_a_o (fxq),
    .quo_b_o (fyq),
    .ovf_o   (ovfb),
    .pay_o   (ovf_prev)
  );

  assign out_valid_o = divb_vld;
  assign rotated_x_o = COORD_BITS'(fxq) <<< DROP;
  assign rotated_y_o = COORD_BITS'(fyq) <<< DROP;
  assign overflow_o  = ovfb || ovf_prev;

endmodule

// ----- rtl/pdrot_div.sv -----
// Pipelined complex quotient divider of the Poincare disk rotation unit.
// Divides two signed numerators by one unsigned divisor, one quotient bit per
// step stage, rounds half away from zero and saturates. Depends on nothing else.
module pdrot_div #(
  parameter int FRAC = 15,
  parameter int NW   = 37,
  parameter int DW   = 21,
  parameter int PW   = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [NW-1:0] num_a_i,
  input  logic signed [NW-1:0] num_b_i,
  input  logic        [DW-1:0] den_i,
  input  logic        [PW-1:0] pay_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [FRAC:0] quo_a_o,
  output logic signed [FRAC:0] quo_b_o,
  output logic                 ovf_o,
  output logic        [PW-1:0] pay_o
);

  localparam int QW = FRAC + 1;
  localparam int MW = NW + 1;

  logic          vld_q [0:QW];
  logic          rdy   [0:QW+1];
  logic [DW-1:0] ra_q  [0:QW];
  logic [DW-1:0] rb_q  [0:QW];
  logic [QW-1:0] la_q  [0:QW];
  logic [QW-1:0] lb_q  [0:QW];
  logic [QW-1:0] qa_q  [0:QW];
  logic [QW-1:0] qb_q  [0:QW];
  logic [DW-1:0] d_q   [0:QW];
  logic          sa_q  [0:QW];
  logic          sb_q  [0:QW];
  logic          ba_q  [0:QW];
  logic          bb_q  [0:QW];
  logic          z_q   [0:QW];
  logic [PW-1:0] pl_q  [0:QW];

  logic                 out_vld_q;
  logic signed [FRAC:0] qa_out_q;
  logic signed [FRAC:0] qb_out_q;
  logic                 ovf_q;
  logic [PW-1:0]        pay_q;

  // Preparation: magnitudes plus half the divisor, and the early overflow test.
  logic signed [MW-1:0] a_ext;
  logic signed [MW-1:0] b_ext;
  logic        [MW-1:0] na;
  logic        [MW-1:0] nb;
  logic                 big_a;
  logic                 big_b;

  always_comb begin
    a_ext = MW'(num_a_i);
    b_ext = MW'(num_b_i);
    na    = (a_ext[MW-1] ? MW'(-a_ext) : MW'(a_ext)) + MW'(den_i >> 1);
    nb    = (b_ext[MW-1] ? MW'(-b_ext) : MW'(b_ext)) + MW'(den_i >> 1);
    big_a = (na >> QW) >= MW'(den_i);
    big_b = (nb >> QW) >= MW'(den_i);
  end

  assign ready_o = rdy[0];

  always_comb begin
    rdy[QW+1] = !out_vld_q || ready_i;
    for (int k = QW; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      ra_q[0] <= big_a ? '0 : DW'(na >> QW);
      rb_q[0] <= big_b ? '0 : DW'(nb >> QW);
      la_q[0] <= na[QW-1:0];
      lb_q[0] <= nb[QW-1:0];
      qa_q[0] <= '0;
      qb_q[0] <= '0;
      d_q[0]  <= den_i;
      sa_q[0] <= num_a_i[NW-1];
      sb_q[0] <= num_b_i[NW-1];
      ba_q[0] <= big_a;
      bb_q[0] <= big_b;
      z_q[0]  <= (den_i == '0);
      pl_q[0] <= pay_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DW:0] ta;
    logic [DW:0] tb;
    logic        ga;
    logic        gb;

    always_comb begin
      ta = {ra_q[k-1], la_q[k-1][QW-k]};
      tb = {rb_q[k-1], lb_q[k-1][QW-k]};
      ga = ta >= {1'b0, d_q[k-1]};
      gb = tb >= {1'b0, d_q[k-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        ra_q[k] <= ga ? DW'(ta - {1'b0, d_q[k-1]}) : DW'(ta);
        rb_q[k] <= gb ? DW'(tb - {1'b0, d_q[k-1]}) : DW'(tb);
        la_q[k] <= la_q[k-1];
        lb_q[k] <= lb_q[k-1];
        qa_q[k] <= {qa_q[k-1][QW-2:0], ga};
        qb_q[k] <= {qb_q[k-1][QW-2:0], gb};
        d_q[k]  <= d_q[k-1];
        sa_q[k] <= sa_q[k-1];
        sb_q[k] <= sb_q[k-1];
        ba_q[k] <= ba_q[k-1];
        bb_q[k] <= bb_q[k-1];
        z_q[k]  <= z_q[k-1];
        pl_q[k] <= pl_q[k-1];
      end
    end
  end

  // Saturation: positive results stop at 2^FRAC - 1, negative ones at -2^FRAC.
  logic          sat_a;
  logic          sat_b;
  logic [QW-1:0] mag_a;
  logic [QW-1:0] mag_b;
  logic [QW-1:0] lim_pos;
  logic [QW-1:0] lim_neg;

  always_comb begin
    lim_pos = {1'b0, {(QW-1){1'b1}}};
    lim_neg = {1'b1, {(QW-1){1'b0}}};
    sat_a   = ba_q[QW] || qa_q[QW][QW-1] && (sa_q[QW] ? |qa_q[QW][QW-2:0] : 1'b1);
    sat_b   = bb_q[QW] || qb_q[QW][QW-1] && (sb_q[QW] ? |qb_q[QW][QW-2:0] : 1'b1);
    mag_a   = sat_a ? (sa_q[QW] ? lim_neg : lim_pos) : qa_q[QW];
    mag_b   = sat_b ? (sb_q[QW] ? lim_neg : lim_pos) : qb_q[QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[QW+1]) begin
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[QW+1] && vld_q[QW]) begin
      if (z_q[QW]) begin
        qa_out_q <= '0;
        qb_out_q <= '0;
        ovf_q    <= 1'b1;
      end else begin
        qa_out_q <= sa_q[QW] ? -$signed(mag_a) : $signed(mag_a);
        qb_out_q <= sb_q[QW] ? -$signed(mag_b) : $signed(mag_b);
        ovf_q    <= sat_a || sat_b;
      end
      pay_q <= pl_q[QW];
    end
  end

  assign valid_o = out_vld_q;
  assign quo_a_o = qa_out_q;
  assign quo_b_o = qb_out_q;
  assign ovf_o   = ovf_q;
  assign pay_o   = pay_q;

endmodule

// ----- rtl/pdrot_chk.sv -----
// Port checker for the Poincare disk rotation unit, bound to its top level.
// Depends on pdrot_pkg for the default coordinate width.
module pdrot_chk
  import pdrot_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [2:0]                   paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic signed [COORD_BITS-1:0] center_x_i,
  input logic signed [COORD_BITS-1:0] center_y_i,
  input logic signed [COORD_BITS-1:0] point_x_i,
  input logic signed [COORD_BITS-1:0] point_y_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [COORD_BITS-1:0] rotated_x_o,
  input logic signed [COORD_BITS-1:0] rotated_y_o,
  input logic                         overflow_o
);

  // The input side can only be held off by a full pipeline behind a blocked result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output side was free");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rotated_x_o) && $stable(rotated_y_o)
                                   && $stable(overflow_o))
    else $error("stalled result changed");

endmodule

bind poincare_disk_rotate_about_point_unit pdrot_chk #(.COORD_BITS(COORD_BITS)) u_pdrot_chk (.*);
